FILE: rtl/vdh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdh_pkg: shared types and constants of the voxel density histogram
// Grid size, derived widths, register map, codes and the beat and command
// structures that pass between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package vdh_pkg;

  // Grid geometry: RES voxels along each axis.
  localparam int RES     = 16;
  localparam int CELL_W  = $clog2(RES);
  localparam int NCELLS  = RES * RES * RES;
  localparam int ADDR_W  = $clog2(NCELLS);

  // Center arithmetic widths: (2i+1)*voxel_km, twice the center, the center.
  localparam int PROD_W  = CELL_W + 20;
  localparam int TW_W    = CELL_W + 21;
  localparam int PX_W    = CELL_W + 20;
  localparam int DIST_W  = 2 * PX_W + 2;

  // Command queue between the front end and the back end.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Configuration port.
  localparam int PADDR_W = 6;
  localparam int PDATA_W = 64;

  localparam logic [2:0] REG_BOUND_KM      = 3'd0;
  localparam logic [2:0] REG_CELLS_PER_KM  = 3'd1;
  localparam logic [2:0] REG_VOXEL_KM      = 3'd2;
  localparam logic [2:0] REG_CORE_LIMIT_SQ = 3'd3;
  localparam logic [2:0] REG_HIGH_THRESH   = 3'd4;
  localparam logic [2:0] REG_MID_THRESH    = 3'd5;

  localparam logic [18:0] BOUND_KM_RST      = 19'd51025;
  localparam logic [23:0] CELLS_PER_KM_RST  = 24'd2630;
  localparam logic [18:0] VOXEL_KM_RST      = 19'd6378;
  localparam logic [39:0] CORE_LIMIT_SQ_RST = 40'd47449889;
  localparam logic [15:0] HIGH_THRESH_RST   = 16'd8;
  localparam logic [15:0] MID_THRESH_RST    = 16'd4;

  // Result kinds.
  localparam logic [2:0] KIND_ACK     = 3'd0;
  localparam logic [2:0] KIND_READING = 3'd1;
  localparam logic [2:0] KIND_ACTIVE  = 3'd2;
  localparam logic [2:0] KIND_SKIPPED = 3'd3;
  localparam logic [2:0] KIND_DONE    = 3'd4;

  // Color classes.
  localparam logic [1:0] COLOR_LOW    = 2'd0;
  localparam logic [1:0] COLOR_MEDIUM = 2'd1;
  localparam logic [1:0] COLOR_HIGH   = 2'd2;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_SCAN  = 2'd3
  } vdh_mode_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_ADD_WR,
    ST_QUERY_RD,
    ST_SCAN_SQ,
    ST_SCAN_SUM,
    ST_SCAN_CMP,
    ST_EMIT
  } vdh_state_t;

  typedef struct packed {
    logic [18:0] bound_km;
    logic [23:0] cells_per_km_q24;
    logic [18:0] voxel_km;
    logic [39:0] core_limit_sq;
    logic [15:0] high_threshold;
    logic [15:0] mid_threshold;
  } vdh_cfg_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [19:0] pos_z;
    logic               visible;
  } vdh_item_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [15:0]        count;
    logic [3:0]         cell_x;
    logic [3:0]         cell_y;
    logic [3:0]         cell_z;
    logic signed [19:0] center_x;
    logic signed [19:0] center_y;
    logic signed [19:0] center_z;
    logic [1:0]         color_class;
  } vdh_result_t;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    vdh_mode_t         mode;
    logic              in_range;
    logic              visible;
    logic [CELL_W-1:0] bin_x;
    logic [CELL_W-1:0] bin_y;
    logic [CELL_W-1:0] bin_z;
  } vdh_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/vdh_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdh_front: input stage and position classifier
// Accepts item beats, bins each axis against the cube bounds and holds the
// classified command until the queue takes it.
// ----------------------------------------------------------------------------
module vdh_front import vdh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  vdh_cfg_t  cfg,
  input  logic      item_valid,
  output logic      item_stall,
  input  vdh_item_t item,
  input  logic      busy,
  input  logic      q_full,
  output logic      push,
  output vdh_cmd_t  cmd
);

  logic     cmd_valid;
  logic     accept;
  vdh_cmd_t cmd_next;
  logic [CELL_W:0] bx;
  logic [CELL_W:0] by;
  logic [CELL_W:0] bz;

  // Returns {inside, bin}: inside when |p| < bound and the bin is below RES.
  function automatic logic [CELL_W:0] axis_bin(logic signed [19:0] p,
                                               logic [18:0] b,
                                               logic [23:0] k);
    logic [19:0] mag;
    logic [19:0] sum;
    logic [43:0] prod;
    logic [19:0] q;
    logic        ok;
    mag  = p[19] ? (~p + 20'd1) : p;
    sum  = p + {1'b0, b};
    prod = 44'(sum) * 44'(k);
    q    = prod[43:24];
    ok   = (mag < {1'b0, b}) && (q < 20'(RES));
    return {ok, q[CELL_W-1:0]};
  endfunction

  // Hold off new beats while the command register waits or the store clears.
  assign item_stall = (cmd_valid && q_full) || busy;
  assign accept     = item_valid && !item_stall;
  assign push       = cmd_valid && !q_full;

  // Classify the incoming beat.
  always_comb begin
    bx = axis_bin(item.pos_x, cfg.bound_km, cfg.cells_per_km_q24);
    by = axis_bin(item.pos_y, cfg.bound_km, cfg.cells_per_km_q24);
    bz = axis_bin(item.pos_z, cfg.bound_km, cfg.cells_per_km_q24);
    cmd_next.mode     = vdh_mode_t'(item.mode);
    cmd_next.in_range = bx[CELL_W] && by[CELL_W] && bz[CELL_W];
    cmd_next.visible  = item.visible;
    cmd_next.bin_x    = bx[CELL_W-1:0];
    cmd_next.bin_y    = by[CELL_W-1:0];
    cmd_next.bin_z    = bz[CELL_W-1:0];
  end

  // Command register occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (accept) begin
      cmd_valid <= 1'b1;
    end else if (push) begin
      cmd_valid <= 1'b0;
    end
  end

  // Command register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/vdh_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdh_queue: command queue
// A short first-in first-out buffer of classified commands so that the front
// end and the back end stall independently.
// ----------------------------------------------------------------------------
module vdh_queue import vdh_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  vdh_cmd_t push_cmd,
  input  logic     pop,
  output vdh_cmd_t head,
  output logic     full,
  output logic     empty
);

  vdh_cmd_t          entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign full    = (fill == QCNT_W'(QDEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/vdh_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdh_back: histogram store and command sequencer
// Owns the hit count memory and the scan position, runs clear sweeps,
// read-modify-write adds, queries and scan steps, and drives the result beat.
// ----------------------------------------------------------------------------
module vdh_back import vdh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  vdh_cfg_t    cfg,
  input  vdh_cmd_t    head,
  input  logic        q_empty,
  output logic        pop,
  output logic        busy,
  output logic        result_valid,
  input  logic        result_stall,
  output vdh_result_t result
);

  vdh_state_t state;
  vdh_state_t state_next;

  // Hit count memory.
  logic [15:0]       mem [NCELLS];
  logic [15:0]       rdata;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  // Control state.
  logic [ADDR_W-1:0] sweep_addr;
  logic              sweep_last;
  logic              sweep_ack;
  logic [CELL_W-1:0] sx;
  logic [CELL_W-1:0] sy;
  logic [CELL_W-1:0] sz;
  logic              scan_done;
  logic              out_free;

  // Datapath registers.
  vdh_result_t            pend;
  logic [ADDR_W-1:0]      op_addr;
  logic signed [PX_W-1:0] cx;
  logic signed [PX_W-1:0] cy;
  logic signed [PX_W-1:0] cz;
  logic [2*PX_W-1:0]      sq_x;
  logic [2*PX_W-1:0]      sq_y;
  logic [2*PX_W-1:0]      sq_z;
  logic [DIST_W-1:0]      radius_sq;
  logic [15:0]            cnt;

  logic [ADDR_W-1:0]      head_addr;
  logic [ADDR_W-1:0]      scan_addr;
  logic [15:0]            sat_inc;
  logic signed [PX_W-1:0] px;
  logic signed [PX_W-1:0] py;
  logic signed [PX_W-1:0] pz;
  vdh_result_t            pend_init;

  // Linear address of a voxel, z fastest.
  function automatic logic [ADDR_W-1:0] cell_addr(logic [CELL_W-1:0] x,
                                                  logic [CELL_W-1:0] y,
                                                  logic [CELL_W-1:0] z);
    logic [ADDR_W-1:0] xy;
    xy = ADDR_W'(x) * ADDR_W'(RES) + ADDR_W'(y);
    return xy * ADDR_W'(RES) + ADDR_W'(z);
  endfunction

  // Floor of -bound + i*voxel + voxel/2, worked out at twice the scale.
  function automatic logic signed [PX_W-1:0] center_of(logic [CELL_W-1:0] i,
                                                       logic [18:0] b,
                                                       logic [18:0] v);
    logic [PROD_W-1:0] prod;
    logic [TW_W-1:0]   twice;
    prod  = PROD_W'({i, 1'b1}) * PROD_W'(v);
    twice = TW_W'(prod) - TW_W'({b, 1'b0});
    return twice[TW_W-1:1];
  endfunction

  assign head_addr  = cell_addr(head.bin_x, head.bin_y, head.bin_z);
  assign scan_addr  = cell_addr(sx, sy, sz);
  assign sweep_last = (sweep_addr == ADDR_W'(NCELLS - 1));
  assign out_free   = !result_valid || !result_stall;
  assign sat_inc    = (rdata == 16'hFFFF) ? rdata : rdata + 16'd1;
  assign px         = center_of(sx, cfg.bound_km, cfg.voxel_km);
  assign py         = center_of(sy, cfg.bound_km, cfg.voxel_km);
  assign pz         = center_of(sz, cfg.bound_km, cfg.voxel_km);

  // Memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_SWEEP: begin
        if (sweep_last) begin
          state_next = sweep_ack ? ST_EMIT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          case (head.mode)
            MODE_CLEAR: state_next = ST_SWEEP;
            MODE_ADD:   state_next = (head.visible && head.in_range) ? ST_ADD_WR : ST_EMIT;
            MODE_QUERY: state_next = head.in_range ? ST_QUERY_RD : ST_EMIT;
            MODE_SCAN:  state_next = scan_done ? ST_EMIT : ST_SCAN_SQ;
            default:    state_next = ST_EMIT;
          endcase
        end
      end
      ST_ADD_WR:   state_next = ST_EMIT;
      ST_QUERY_RD: state_next = ST_EMIT;
      ST_SCAN_SQ:  state_next = ST_SCAN_SUM;
      ST_SCAN_SUM: state_next = ST_SCAN_CMP;
      ST_SCAN_CMP: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs: queue pop, busy and memory ports.
  always_comb begin
    pop       = 1'b0;
    busy      = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = sweep_addr;
    mem_wdata = 16'd0;
    mem_raddr = scan_addr;
    case (state)
      ST_SWEEP: begin
        busy   = 1'b1;
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        pop       = !q_empty;
        mem_raddr = (head.mode == MODE_SCAN) ? scan_addr : head_addr;
      end
      ST_ADD_WR: begin
        mem_we    = 1'b1;
        mem_waddr = op_addr;
        mem_wdata = sat_inc;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // First contents of the pending result for the command at the queue head.
  always_comb begin
    pend_init = '0;
    case (head.mode)
      MODE_QUERY: begin
        pend_init.kind = KIND_READING;
        if (head.in_range) begin
          pend_init.cell_x = 4'(head.bin_x);
          pend_init.cell_y = 4'(head.bin_y);
          pend_init.cell_z = 4'(head.bin_z);
        end
      end
      MODE_SCAN: begin
        if (scan_done) begin
          pend_init.kind = KIND_DONE;
        end else begin
          pend_init.cell_x   = 4'(sx);
          pend_init.cell_y   = 4'(sy);
          pend_init.cell_z   = 4'(sz);
          pend_init.center_x = 20'(px);
          pend_init.center_y = 20'(py);
          pend_init.center_z = 20'(pz);
        end
      end
      default: begin
        pend_init.kind = KIND_ACK;
      end
    endcase
  end

  // Control registers: state, sweep, scan position and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_SWEEP;
      sweep_addr   <= '0;
      sweep_ack    <= 1'b0;
      sx           <= '0;
      sy           <= '0;
      sz           <= '0;
      scan_done    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (state == ST_SWEEP) begin
        sweep_addr <= sweep_last ? '0 : sweep_addr + 1'b1;
        if (sweep_last) begin
          sweep_ack <= 1'b0;
        end
      end

      if (state == ST_IDLE && !q_empty) begin
        if (head.mode == MODE_CLEAR) begin
          sweep_addr <= '0;
          sweep_ack  <= 1'b1;
          sx         <= '0;
          sy         <= '0;
          sz         <= '0;
          scan_done  <= 1'b0;
        end else if (head.mode == MODE_SCAN && scan_done) begin
          scan_done <= 1'b0;
        end
      end

      // Step the scan position, z fastest, as each voxel is compared.
      if (state == ST_SCAN_CMP) begin
        if (sz == CELL_W'(RES - 1)) begin
          sz <= '0;
          if (sy == CELL_W'(RES - 1)) begin
            sy <= '0;
            if (sx == CELL_W'(RES - 1)) begin
              sx        <= '0;
              scan_done <= 1'b1;
            end else begin
              sx <= sx + 1'b1;
            end
          end else begin
            sy <= sy + 1'b1;
          end
        end else begin
          sz <= sz + 1'b1;
        end
      end

      if (state == ST_EMIT && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Datapath registers: pending result, centers, squares and distance.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          pend    <= pend_init;
          op_addr <= head_addr;
          if (head.mode == MODE_SCAN) begin
            cx <= px;
            cy <= py;
            cz <= pz;
          end
        end
      end
      ST_QUERY_RD: begin
        pend.count <= rdata;
      end
      ST_SCAN_SQ: begin
        cnt  <= rdata;
        sq_x <= cx * cx;
        sq_y <= cy * cy;
        sq_z <= cz * cz;
      end
      ST_SCAN_SUM: begin
        radius_sq <= DIST_W'(sq_x) + DIST_W'(sq_y) + DIST_W'(sq_z);
      end
      ST_SCAN_CMP: begin
        pend.count <= cnt;
        if (cnt != 16'd0 && radius_sq >= DIST_W'(cfg.core_limit_sq)) begin
          pend.kind <= KIND_ACTIVE;
          if (cnt > cfg.high_threshold) begin
            pend.color_class <= COLOR_HIGH;
          end else if (cnt > cfg.mid_threshold) begin
            pend.color_class <= COLOR_MEDIUM;
          end else begin
            pend.color_class <= COLOR_LOW;
          end
        end else begin
          pend.kind        <= KIND_SKIPPED;
          pend.color_class <= COLOR_LOW;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          result <= pend;
        end
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/voxel_density_histogram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_density_histogram: 3-D voxel hit count histogram
// Counts object positions in a cubic grid of saturating counters, answers
// point queries and scans the grid for occupied voxels outside a core radius.
// ----------------------------------------------------------------------------
// Usage:
//   Item beats (mode, position, visible) enter on item_valid/item_stall; one
//   result beat per item leaves on result_valid/result_stall, in order.
//   Settings are written through the APB-style port at byte address 8*index
//   by the user only while the block is idle; the block does not enforce it;
//   reads return the current register values.
// Sequencing:
//   The back-end sequencer runs one command at a time: a counted add reads
//   and writes back the count memory, an in-range query reads it, a scan
//   step goes through memory read, squares, sum, compare and result, and the
//   other adds, queries and the finished scan go straight to the result. The
//   rate is limited by the single read port and the read-modify-write of the
//   count memory; the front end and queue take further items meanwhile.
// Reset and clear:
//   After reset, and after every clear item, a sweep writes zero to all
//   4096 voxels, one per cycle; item_stall stays high for those cycles.
// Back pressure:
//   A stalled result holds; four further items are taken, one into the
//   sequencer, two into the command queue and one into the input register,
//   before item_stall rises.
// ----------------------------------------------------------------------------
module voxel_density_histogram import vdh_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               item_valid,
  output logic               item_stall,
  input  vdh_item_t          item,
  output logic               result_valid,
  input  logic               result_stall,
  output vdh_result_t        result
);

  vdh_cfg_t   cfg;
  logic       cfg_we;
  logic [2:0] reg_idx;
  logic       busy;
  logic       push;
  vdh_cmd_t   front_cmd;
  vdh_cmd_t   head;
  logic       q_full;
  logic       q_empty;
  logic       pop;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:3];
  assign cfg_we  = psel && penable && pwrite && pready;

  // Settings registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bound_km         <= BOUND_KM_RST;
      cfg.cells_per_km_q24 <= CELLS_PER_KM_RST;
      cfg.voxel_km         <= VOXEL_KM_RST;
      cfg.core_limit_sq    <= CORE_LIMIT_SQ_RST;
      cfg.high_threshold   <= HIGH_THRESH_RST;
      cfg.mid_threshold    <= MID_THRESH_RST;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_BOUND_KM:      cfg.bound_km         <= pwdata[18:0];
        REG_CELLS_PER_KM:  cfg.cells_per_km_q24 <= pwdata[23:0];
        REG_VOXEL_KM:      cfg.voxel_km         <= pwdata[18:0];
        REG_CORE_LIMIT_SQ: cfg.core_limit_sq    <= pwdata[39:0];
        REG_HIGH_THRESH:   cfg.high_threshold   <= pwdata[15:0];
        REG_MID_THRESH:    cfg.mid_threshold    <= pwdata[15:0];
        default:           cfg.mid_threshold    <= cfg.mid_threshold;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      REG_BOUND_KM:      prdata = PDATA_W'(cfg.bound_km);
      REG_CELLS_PER_KM:  prdata = PDATA_W'(cfg.cells_per_km_q24);
      REG_VOXEL_KM:      prdata = PDATA_W'(cfg.voxel_km);
      REG_CORE_LIMIT_SQ: prdata = PDATA_W'(cfg.core_limit_sq);
      REG_HIGH_THRESH:   prdata = PDATA_W'(cfg.high_threshold);
      REG_MID_THRESH:    prdata = PDATA_W'(cfg.mid_threshold);
      default:           prdata = '0;
    endcase
  end

  vdh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .busy       (busy),
    .q_full     (q_full),
    .push       (push),
    .cmd        (front_cmd)
  );

  vdh_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (front_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  vdh_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (head),
    .q_empty      (q_empty),
    .pop          (pop),
    .busy         (busy),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
`default_nettype wire
